// File: rtl/core/chebmp_pkg.sv
package chebmp_pkg;

    // Width of one residue and the prime that all arithmetic is reduced by.
    localparam int RES_W = 30;
    localparam logic [RES_W-1:0] PRIME = 30'd1000000007;

    // Exponent that turns a residue into its inverse (Fermat).
    localparam logic [RES_W-1:0] INV_EXP = 30'd1000000005;

    // Width of the degree field on the port and default width actually used.
    localparam int STEP_W        = 60;
    localparam int STEP_BITS_DEF = 60;

    // Bit counter of the serial multiplier.
    localparam int CNT_W = $clog2(RES_W);

    // Request to the shared modular multiply-add unit: result = (a * b + c) mod PRIME.
    typedef struct packed {
        logic             start;
        logic [RES_W-1:0] a;
        logic [RES_W-1:0] b;
        logic [RES_W-1:0] c;
    } mm_req_t;

    // Response of the unit; result is valid while done is high.
    typedef struct packed {
        logic             done;
        logic [RES_W-1:0] result;
    } mm_rsp_t;

endpackage

// File: rtl/core/chebmp_modmul.sv
module chebmp_modmul
    import chebmp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  mm_req_t req,
    output mm_rsp_t rsp
);

    // Interleaved multiplication, one bit of b per cycle from the top, followed
    // by a step that adds the addend c.
    logic             busy_reg;
    logic             add_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [RES_W-1:0] acc_reg;
    logic [RES_W-1:0] a_reg;
    logic [RES_W-1:0] b_reg;
    logic [RES_W-1:0] c_reg;

    logic [RES_W+1:0] step_sum;
    logic [RES_W+1:0] step_red;
    logic [RES_W+1:0] add_sum;
    logic [RES_W+1:0] add_red;

    localparam logic [RES_W+1:0] P_X  = {2'b00, PRIME};
    localparam logic [RES_W+1:0] P2_X = {1'b0, PRIME, 1'b0};

    always_comb begin
        // Doubled accumulator plus the partial product stays below three primes.
        step_sum = {1'b0, acc_reg, 1'b0} + (b_reg[RES_W-1] ? {2'b00, a_reg} : '0);
        if (step_sum >= P2_X) begin
            step_red = step_sum - P2_X;
        end else if (step_sum >= P_X) begin
            step_red = step_sum - P_X;
        end else begin
            step_red = step_sum;
        end
        add_sum = {2'b00, acc_reg} + {2'b00, c_reg};
        if (add_sum >= P_X) begin
            add_red = add_sum - P_X;
        end else begin
            add_red = add_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            add_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                a_reg    <= req.a;
                b_reg    <= req.b;
                c_reg    <= req.c;
                acc_reg  <= '0;
                cnt_reg  <= '0;
                add_reg  <= 1'b0;
                busy_reg <= 1'b1;
            end else if (busy_reg && !add_reg) begin
                acc_reg <= step_red[RES_W-1:0];
                b_reg   <= {b_reg[RES_W-2:0], 1'b0};
                if (cnt_reg == CNT_W'(RES_W - 1)) begin
                    add_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end else if (busy_reg) begin
                acc_reg  <= add_red[RES_W-1:0];
                busy_reg <= 1'b0;
                add_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = acc_reg;

endmodule

// File: rtl/core/chebyshev_mod_prime_evaluator.sv
// Evaluates l * T_t(d / l) modulo the prime 1000000007 for one transaction at a time.
// Every product goes through a single shared modular multiply-add unit that
// handles one multiplier bit per cycle. An item needs N_inv + 3 + 8 * N_mat
// products, where N_inv is 45 (30 squarings plus 15 multiplications for the inverse
// of l) and N_mat is the number of matrix products for t - 1: one squaring per bit
// up to its highest set bit plus one product per set bit. For a degree of zero the
// result is l itself and is returned without any product. The input is refused
// while an item is at work and until its result transaction has been taken.
module chebyshev_mod_prime_evaluator
    import chebmp_pkg::*;
#(
    parameter int STEP_BITS = STEP_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // Fields from bit 0: length_value[29:0], offset_value[59:30], step_count[119:60].
    input  logic [119:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // Fields from bit 0: result_value[29:0], then two zero bits.
    output logic [31:0]  m_tdata
);

    // Only the degree bits that exist on the port and below STEP_BITS count.
    localparam int EXP_W = (STEP_BITS < STEP_W) ? STEP_BITS : STEP_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INV,
        ST_RATIO,
        ST_BASE,
        ST_MAT,
        ST_FIN1,
        ST_FIN2,
        ST_OUT
    } state_t;

    state_t state_reg;
    logic   pend_reg;

    logic [RES_W-1:0] len_reg, off_reg, ratio_reg, res_reg, result_reg;
    logic [RES_W-1:0] pow_acc_reg, pow_base_reg;
    logic [CNT_W-1:0] inv_idx_reg;
    logic             inv_phase_reg;
    logic [EXP_W-1:0] exp_reg;
    logic             mat_phase_reg;
    logic [2:0]       mstep_reg;
    logic [RES_W-1:0] tmp_reg;
    logic [RES_W-1:0] prod0_reg, prod1_reg, prod2_reg;
    logic [RES_W-1:0] acc0_reg, acc1_reg, acc2_reg, acc3_reg;
    logic [RES_W-1:0] base0_reg, base1_reg, base2_reg, base3_reg;

    mm_req_t mm_req;
    mm_rsp_t mm_rsp;

    logic [RES_W-1:0] in_len, in_off, in_len_red, in_off_red;
    logic [EXP_W-1:0] in_step;
    logic [RES_W:0]   dbl_ratio, dbl_red;
    logic [RES_W-1:0] left0, left1, left2, left3;
    logic [RES_W-1:0] mat_a, mat_b;

    assign in_len  = s_tdata[29:0];
    assign in_off  = s_tdata[59:30];
    assign in_step = s_tdata[60 +: EXP_W];

    // A 30-bit value is below twice the prime, so one subtraction reduces it.
    assign in_len_red = (in_len >= PRIME) ? in_len - PRIME : in_len;
    assign in_off_red = (in_off >= PRIME) ? in_off - PRIME : in_off;

    assign dbl_ratio = {ratio_reg, 1'b0};
    assign dbl_red   = (dbl_ratio >= {1'b0, PRIME}) ? dbl_ratio - {1'b0, PRIME} : dbl_ratio;

    // Left factor of the matrix product: the running power or the base itself.
    assign left0 = mat_phase_reg ? base0_reg : acc0_reg;
    assign left1 = mat_phase_reg ? base1_reg : acc1_reg;
    assign left2 = mat_phase_reg ? base2_reg : acc2_reg;
    assign left3 = mat_phase_reg ? base3_reg : acc3_reg;

    // Each entry of the product takes two steps: the first term, then the
    // second term added to it.
    always_comb begin
        case (mstep_reg)
            3'd0: begin mat_a = left0; mat_b = base0_reg; end
            3'd1: begin mat_a = left1; mat_b = base2_reg; end
            3'd2: begin mat_a = left0; mat_b = base1_reg; end
            3'd3: begin mat_a = left1; mat_b = base3_reg; end
            3'd4: begin mat_a = left2; mat_b = base0_reg; end
            3'd5: begin mat_a = left3; mat_b = base2_reg; end
            3'd6: begin mat_a = left2; mat_b = base1_reg; end
            3'd7: begin mat_a = left3; mat_b = base3_reg; end
            default: begin mat_a = left0; mat_b = base0_reg; end
        endcase
    end

    // Operands and start of the shared unit for the current state.
    always_comb begin
        mm_req = '0;
        case (state_reg)
            ST_INV: begin
                mm_req.start = !pend_reg && (inv_phase_reg || INV_EXP[inv_idx_reg]);
                mm_req.a     = inv_phase_reg ? pow_base_reg : pow_acc_reg;
                mm_req.b     = pow_base_reg;
            end
            ST_RATIO: begin
                mm_req.start = !pend_reg;
                mm_req.a     = off_reg;
                mm_req.b     = pow_acc_reg;
            end
            ST_MAT: begin
                mm_req.start = !pend_reg && (exp_reg != '0) && (mat_phase_reg || exp_reg[0]);
                mm_req.a     = mat_a;
                mm_req.b     = mat_b;
                mm_req.c     = mstep_reg[0] ? tmp_reg : '0;
            end
            ST_FIN1: begin
                mm_req.start = !pend_reg;
                mm_req.a     = ratio_reg;
                mm_req.b     = acc3_reg;
                mm_req.c     = acc1_reg;
            end
            ST_FIN2: begin
                mm_req.start = !pend_reg;
                mm_req.a     = res_reg;
                mm_req.b     = len_reg;
            end
            default: begin
                mm_req = '0;
            end
        endcase
    end

    chebmp_modmul u_modmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mm_req),
        .rsp     (mm_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
        end else begin
            if (mm_req.start) begin
                pend_reg <= 1'b1;
            end else if (mm_rsp.done) begin
                pend_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        len_reg <= in_len_red;
                        off_reg <= in_off_red;
                        if (in_step == '0) begin
                            // Degree zero: T_0 is one, so the answer is l itself.
                            result_reg <= in_len_red;
                            state_reg  <= ST_OUT;
                        end else begin
                            exp_reg       <= in_step - EXP_W'(1);
                            pow_acc_reg   <= RES_W'(1);
                            pow_base_reg  <= in_len_red;
                            inv_idx_reg   <= '0;
                            inv_phase_reg <= 1'b0;
                            state_reg     <= ST_INV;
                        end
                    end
                end
                ST_INV: begin
                    if (!pend_reg && !inv_phase_reg && !INV_EXP[inv_idx_reg]) begin
                        inv_phase_reg <= 1'b1;
                    end else if (mm_rsp.done) begin
                        if (!inv_phase_reg) begin
                            pow_acc_reg   <= mm_rsp.result;
                            inv_phase_reg <= 1'b1;
                        end else begin
                            pow_base_reg  <= mm_rsp.result;
                            inv_phase_reg <= 1'b0;
                            if (inv_idx_reg == CNT_W'(RES_W - 1)) begin
                                state_reg <= ST_RATIO;
                            end else begin
                                inv_idx_reg <= inv_idx_reg + CNT_W'(1);
                            end
                        end
                    end
                end
                ST_RATIO: begin
                    if (mm_rsp.done) begin
                        ratio_reg <= mm_rsp.result;
                        state_reg <= ST_BASE;
                    end
                end
                ST_BASE: begin
                    // Companion matrix [[0, -1], [1, 2f]] and the identity.
                    base0_reg     <= '0;
                    base1_reg     <= PRIME - RES_W'(1);
                    base2_reg     <= RES_W'(1);
                    base3_reg     <= dbl_red[RES_W-1:0];
                    acc0_reg      <= RES_W'(1);
                    acc1_reg      <= '0;
                    acc2_reg      <= '0;
                    acc3_reg      <= RES_W'(1);
                    mat_phase_reg <= 1'b0;
                    mstep_reg     <= '0;
                    state_reg     <= ST_MAT;
                end
                ST_MAT: begin
                    if (!pend_reg && exp_reg == '0) begin
                        state_reg <= ST_FIN1;
                    end else if (!pend_reg && !mat_phase_reg && !exp_reg[0]) begin
                        mat_phase_reg <= 1'b1;
                    end else if (mm_rsp.done) begin
                        case (mstep_reg)
                            3'd1: prod0_reg <= mm_rsp.result;
                            3'd3: prod1_reg <= mm_rsp.result;
                            3'd5: prod2_reg <= mm_rsp.result;
                            3'd7: begin
                                if (mat_phase_reg) begin
                                    base0_reg <= prod0_reg;
                                    base1_reg <= prod1_reg;
                                    base2_reg <= prod2_reg;
                                    base3_reg <= mm_rsp.result;
                                end else begin
                                    acc0_reg <= prod0_reg;
                                    acc1_reg <= prod1_reg;
                                    acc2_reg <= prod2_reg;
                                    acc3_reg <= mm_rsp.result;
                                end
                            end
                            default: tmp_reg <= mm_rsp.result;
                        endcase
                        mstep_reg <= mstep_reg + 3'd1;
                        if (mstep_reg == 3'd7) begin
                            if (mat_phase_reg) begin
                                mat_phase_reg <= 1'b0;
                                exp_reg       <= exp_reg >> 1;
                            end else begin
                                mat_phase_reg <= 1'b1;
                            end
                        end
                    end
                end
                ST_FIN1: begin
                    if (mm_rsp.done) begin
                        res_reg   <= mm_rsp.result;
                        state_reg <= ST_FIN2;
                    end
                end
                ST_FIN2: begin
                    if (mm_rsp.done) begin
                        result_reg <= mm_rsp.result;
                        state_reg  <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_tready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {2'b00, result_reg};

    // The two channels are never open at the same time.
    assert property (@(posedge aclk) disable iff (!aresetn) !(s_tready && m_tvalid))
        else $error("input and result channels open together");

    // The shared unit is never started while a product is still outstanding.
    assert property (@(posedge aclk) disable iff (!aresetn) mm_req.start |-> !pend_reg)
        else $error("multiplier restarted while busy");

    // A product is only handed back when one was requested.
    assert property (@(posedge aclk) disable iff (!aresetn) mm_rsp.done |-> pend_reg)
        else $error("unexpected multiplier result");

    // Every result is a fully reduced residue.
    assert property (@(posedge aclk) disable iff (!aresetn) m_tvalid |-> (result_reg < PRIME))
        else $error("result not reduced");

endmodule
